// ===== design/fdivmod_pkg.sv =====
// fdivmod_pkg: status codes shared by the floored signed divider
// no dependencies
`default_nettype none

package fdivmod_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_DIV_ZERO = 2'd1;
    localparam status_t STATUS_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== design/floor_divmod_signed.sv =====
// floor_divmod_signed: pipelined floored signed divide with remainder
// depends on fdivmod_pkg for the status codes
`default_nettype none

// channel    direction  handshake              payload
// request    in         in_valid / in_stall    dividend, divisor
// result     out        out_valid / out_stall  quotient, remainder, status
//
// one request accepted per cycle while in_stall is low; each result passes
// stage 0, one restoring subtract stage per quotient bit and the output register
// reset clears only the stage valid bits; payload registers are not reset
// each stage holds its request until the next one down is empty or moving,
// so a stall on the result side fills bubbles before it reaches in_stall
module floor_divmod_signed #(
    parameter int WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [WIDTH-1:0] dividend,
    input  wire logic signed [WIDTH-1:0] divisor,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [WIDTH-1:0]      quotient,
    output logic signed [WIDTH-1:0]      remainder,
    output fdivmod_pkg::status_t         status
);

    // stage 0 takes magnitudes, stages 1..WIDTH each settle one quotient bit
    localparam int LAST = WIDTH;

    // per-stage valid bits and handshake
    logic [LAST:0]   valid_reg;
    logic [LAST+1:0] ready;

    // per-stage payload
    logic [WIDTH-1:0] rem_reg  [0:LAST];   // partial remainder
    logic [WIDTH-1:0] qsh_reg  [0:LAST];   // dividend bits left, quotient bits in
    logic [WIDTH-1:0] bm_reg   [0:LAST];   // divisor magnitude
    logic [WIDTH-1:0] b_reg    [0:LAST];   // divisor as given, for the floor fix
    logic [LAST:0]    sa_reg;              // dividend sign
    logic [LAST:0]    sb_reg;              // divisor sign
    logic [LAST:0]    dz_reg;              // divide by zero
    logic [LAST:0]    ovf_reg;             // most negative over minus one

    logic [WIDTH-1:0] rem_next [1:LAST];
    logic [WIDTH-1:0] qsh_next [1:LAST];

    // output register
    logic                    out_valid_reg;
    logic [WIDTH-1:0]        quot_reg;
    logic [WIDTH-1:0]        rmd_reg;
    fdivmod_pkg::status_t    status_reg;

    logic [WIDTH-1:0]        quot_next;
    logic [WIDTH-1:0]        rmd_next;
    fdivmod_pkg::status_t    status_next;

    // stage 0 front end
    logic [WIDTH-1:0] am_in;
    logic [WIDTH-1:0] bm_in;
    logic             dz_in;
    logic             ovf_in;

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    always_comb
    begin
        am_in  = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
        bm_in  = divisor[WIDTH-1]  ? (~divisor + 1'b1)  : divisor;
        dz_in  = (divisor == '0);
        ovf_in = (dividend == MOST_NEG) && (divisor == {WIDTH{1'b1}});
    end

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        ready[LAST+1] = !out_valid_reg || !out_stall;
        for (int i = LAST; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign in_stall = !ready[0];

    // one restoring step per stage
    always_comb
    begin
        logic [WIDTH:0] trial;
        logic [WIDTH:0] diff;
        trial = '0;
        diff  = '0;
        for (int i = 1; i <= LAST; i++)
        begin
            trial       = {rem_reg[i-1], qsh_reg[i-1][WIDTH-1]};
            diff        = trial - {1'b0, bm_reg[i-1]};
            rem_next[i] = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
            qsh_next[i] = {qsh_reg[i-1][WIDTH-2:0], !diff[WIDTH]};
        end
    end

    // floor correction and special cases
    always_comb
    begin
        logic [WIDTH-1:0] qm;
        logic [WIDTH-1:0] rm;
        logic             qneg;
        logic             fix;
        qm   = qsh_reg[LAST];
        rm   = rem_reg[LAST];
        qneg = sa_reg[LAST] ^ sb_reg[LAST];
        fix  = qneg && (rm != '0);

        // negated then decremented quotient is just the complement
        if (fix)
            quot_next = ~qm;
        else if (qneg)
            quot_next = ~qm + 1'b1;
        else
            quot_next = qm;

        if (fix && sa_reg[LAST])
            rmd_next = b_reg[LAST] - rm;
        else if (fix)
            rmd_next = b_reg[LAST] + rm;
        else if (sa_reg[LAST])
            rmd_next = ~rm + 1'b1;
        else
            rmd_next = rm;

        status_next = fdivmod_pkg::STATUS_OK;
        if (dz_reg[LAST])
        begin
            quot_next   = '0;
            rmd_next    = '0;
            status_next = fdivmod_pkg::STATUS_DIV_ZERO;
        end
        else if (ovf_reg[LAST])
        begin
            status_next = fdivmod_pkg::STATUS_OVERFLOW;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++)
            begin
                if (ready[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
            if (ready[LAST+1])
                out_valid_reg <= valid_reg[LAST];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            rem_reg[0] <= '0;
            qsh_reg[0] <= am_in;
            bm_reg[0]  <= bm_in;
            b_reg[0]   <= divisor;
            sa_reg[0]  <= dividend[WIDTH-1];
            sb_reg[0]  <= divisor[WIDTH-1];
            dz_reg[0]  <= dz_in;
            ovf_reg[0] <= ovf_in;
        end
        for (int i = 1; i <= LAST; i++)
        begin
            if (ready[i] && valid_reg[i-1])
            begin
                rem_reg[i] <= rem_next[i];
                qsh_reg[i] <= qsh_next[i];
                bm_reg[i]  <= bm_reg[i-1];
                b_reg[i]   <= b_reg[i-1];
                sa_reg[i]  <= sa_reg[i-1];
                sb_reg[i]  <= sb_reg[i-1];
                dz_reg[i]  <= dz_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
        if (ready[LAST+1] && valid_reg[LAST])
        begin
            quot_reg   <= quot_next;
            rmd_reg    <= rmd_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quot_reg;
    assign remainder = rmd_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== test/floor_divmod_signed_checker.sv =====
// floor_divmod_signed_checker: watches both channels of the floored divider, predicts each
// result from its request and compares quotient, remainder and status in order
// depends on fdivmod_pkg for the status codes
`timescale 1ns / 1ps

module floor_divmod_signed_checker #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [WIDTH-1:0] dividend,
    input  logic signed [WIDTH-1:0] divisor,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [WIDTH-1:0] quotient,
    input  logic signed [WIDTH-1:0] remainder,
    input  fdivmod_pkg::status_t    status,
    output int                      errors,
    output int                      pending
);

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [WIDTH-1:0]     quotient;
        logic [WIDTH-1:0]     remainder;
        fdivmod_pkg::status_t status;
    } divmod_t;

    divmod_t expected_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // truncating divide on magnitudes, then floor correction when signs differ and the remainder is nonzero
    function automatic divmod_t floor_divmod(input logic [WIDTH-1:0] num,
                                             input logic [WIDTH-1:0] den);
        logic [WIDTH-1:0] num_mag;
        logic [WIDTH-1:0] den_mag;
        logic [WIDTH-1:0] q_mag;
        logic [WIDTH-1:0] r_mag;
        logic             q_neg;
        divmod_t          res;
        res = '0;
        if (den == '0)
        begin
            res.status = fdivmod_pkg::STATUS_DIV_ZERO;
            return res;
        end
        num_mag = num[WIDTH-1] ? -num : num;
        den_mag = den[WIDTH-1] ? -den : den;
        q_mag   = num_mag / den_mag;
        r_mag   = num_mag % den_mag;
        q_neg   = num[WIDTH-1] ^ den[WIDTH-1];
        res.quotient  = q_neg ? -q_mag : q_mag;
        res.remainder = num[WIDTH-1] ? -r_mag : r_mag;
        if (r_mag != '0 && q_neg)
        begin
            res.quotient  = res.quotient - 1'b1;
            res.remainder = res.remainder + den;
        end
        res.status = (num == MOST_NEG && den == '1) ? fdivmod_pkg::STATUS_OVERFLOW
                                                    : fdivmod_pkg::STATUS_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        divmod_t want;
        if (rst_n)
        begin
            // results leave long after their request, so pop before push
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result q=%h r=%h s=%0d with no request pending",
                                              quotient, remainder, status));
                else
                begin
                    want = expected_q.pop_front();
                    if (quotient !== want.quotient)
                        report_mismatch($sformatf("quotient %h, expected %h",
                                                  quotient, want.quotient));
                    if (remainder !== want.remainder)
                        report_mismatch($sformatf("remainder %h, expected %h",
                                                  remainder, want.remainder));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(floor_divmod(dividend, divisor));
            pending = expected_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for the floored signed divider
// depends on fdivmod_pkg, floor_divmod_signed and floor_divmod_signed_checker
`timescale 1ns / 1ps

module tb;

    localparam int WIDTH = 32;
    // pipeline depth of the block: stage 0, one stage per quotient bit and the output register
    localparam int LATENCY = WIDTH + 2;
    localparam int RANDOM_REQUESTS = 500;
    localparam int NUM_PHASES = 4;
    // receiver hold-off long enough to fill every stage and back up the request side
    localparam int HOLD_OFF_CYCLES = 150;
    // cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT = 5000;

    localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic signed [WIDTH-1:0] MOST_POS = ~MOST_NEG;

    // idle and stall percentages per phase: none, sender idle, receiver stall, both
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 63, 0, 38};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 63, 38};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [WIDTH-1:0] dividend  = '0;
    logic signed [WIDTH-1:0] divisor   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [WIDTH-1:0] quotient;
    logic signed [WIDTH-1:0] remainder;
    fdivmod_pkg::status_t    status;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hang_count     = 0;
    bit hold_off_req   = 1'b0;

    floor_divmod_signed #(
        .WIDTH(WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dividend (dividend),
        .divisor  (divisor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quotient (quotient),
        .remainder(remainder),
        .status   (status)
    );

    floor_divmod_signed_checker #(
        .WIDTH(WIDTH)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dividend (dividend),
        .divisor  (divisor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quotient (quotient),
        .remainder(remainder),
        .status   (status),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // hang detection: any accepted request or result clears the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("[floor_divmod_signed] ERROR");
            $finish;
        end
    end

    // result side: random stall per cycle, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one request from a falling edge; valid stays high into the next
    // request unless an idle gap is drawn, payload holds while stalled
    task automatic send_request(input logic signed [WIDTH-1:0] num,
                                input logic signed [WIDTH-1:0] den);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            dividend <= $urandom;
            divisor  <= $urandom;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        dividend <= num;
        divisor  <= den;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [WIDTH-1:0] num;
        logic signed [WIDTH-1:0] den;
        int                      pick;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: sign combinations, exact and inexact, extremes
        send_request(7, 2);
        send_request(-7, 2);
        send_request(7, -2);
        send_request(-7, -2);
        send_request(6, -3);             // exact with signs differing: no correction
        send_request(-6, 3);
        send_request(0, -5);
        send_request(1, 0);              // division by zero
        send_request(MOST_NEG, 0);
        send_request(MOST_POS, 0);
        send_request(0, 0);
        send_request(MOST_NEG, -1);      // quotient overflow wraps
        send_request(MOST_NEG, 1);
        send_request(MOST_POS, -1);
        send_request(MOST_NEG, MOST_NEG);
        send_request(MOST_NEG, MOST_POS);
        send_request(MOST_POS, MOST_NEG);
        send_request(MOST_POS, MOST_POS);
        send_request(1, MOST_NEG);
        send_request(-1, MOST_POS);
        send_request(-1, 1);
        send_request(MOST_NEG + 1, -1);
        send_request(-1, -1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            if (phase == 0)
            begin
                // drop valid so the last request is not offered twice, then
                // ask the receiver for its hold-off away from the falling edge
                in_valid <= 1'b0;
                @(posedge clk);
                hold_off_req = 1'b1;
                @(negedge clk);
            end
            for (int i = 0; i < RANDOM_REQUESTS / NUM_PHASES; i++)
            begin
                pick = $urandom_range(99);
                num  = $urandom;
                den  = $urandom;
                if (pick < 30)
                begin
                    // full range on both operands
                end
                else if (pick < 55)
                begin
                    den = $urandom_range(31);
                    if ($urandom_range(1))
                        den = -den;
                end
                else if (pick < 75)
                begin
                    num = int'($urandom_range(128)) - 64;
                    den = int'($urandom_range(128)) - 64;
                end
                else if (pick < 85)
                begin
                    // divisor close to dividend magnitude: small quotients
                    den = num >>> $urandom_range(4);
                    if ($urandom_range(1))
                        den = -den;
                end
                else if (pick < 90)
                    den = '0;
                else if (pick < 94)
                begin
                    num = MOST_NEG;
                    den = -1;
                end
                else
                begin
                    case ($urandom_range(4))
                        0: num = MOST_NEG;
                        1: num = MOST_POS;
                        2: num = -1;
                        3: num = 0;
                        default: num = 1;
                    endcase
                    case ($urandom_range(4))
                        0: den = MOST_NEG;
                        1: den = MOST_POS;
                        2: den = -1;
                        3: den = 1;
                        default: den = 2;
                    endcase
                end
                send_request(num, den);
            end
        end

        in_valid <= 1'b0;

        // drain: every expected result back, then the pipeline depth once more
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (errors == 0)
            $display("[floor_divmod_signed] OK");
        else
            $display("[floor_divmod_signed] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fdivmod_pkg.sv
design/floor_divmod_signed.sv
test/floor_divmod_signed_checker.sv
test/tb.sv
